@@ sv/mavg_pkg.sv @@
package mavg_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int SAMPLE_W = 32;
  localparam int WL_W     = 7;

  // Default ring depth and the window length after reset.
  localparam int              MAX_WINDOW_DEF = 64;
  localparam logic [WL_W-1:0] WINDOW_RESET   = 7'd50;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_DELIVER
  } mavg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the sample and read the oldest entry
    logic update;   // write the ring, update sum, count and pointer
    logic load;     // load the divider with the magnitude of the sum
    logic step;     // one quotient bit
    logic deliver;  // move the signed quotient to the output register
  } mavg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register empty or being emptied this cycle
  } mavg_status_t;

endpackage

@@ sv/mavg_if.sv @@
// Sample channel: one signed fixed-point sample per item.
interface mavg_sample_if;
  import mavg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: the mean and the fill count for one sample.
interface mavg_result_if;
  import mavg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean;
  logic        [WL_W-1:0]     fill_count;

  modport source (output valid, output mean, output fill_count, input ready);
  modport sink   (input valid, input mean, input fill_count, output ready);
endinterface

@@ sv/mavg_ctrl.sv @@
module mavg_ctrl #(
  parameter int SUM_W = 38
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mavg_pkg::mavg_status_t sts,
  output mavg_pkg::mavg_cmd_t    cmd
);
  import mavg_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  mavg_state_t       state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  // State and quotient bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load      = 1'b1;
        step_cnt_next = STEP_W'(SUM_W - 1);
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_DELIVER;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      ST_DELIVER: begin
        // Wait until the output register can take the result.
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/mavg_dp.sv @@
module mavg_dp #(
  parameter int MAX_WINDOW = 64,
  parameter int SUM_W      = 38
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic        [mavg_pkg::WL_W-1:0]      cfg_wr_data,
  input  logic signed [mavg_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [mavg_pkg::SAMPLE_W-1:0]  mean,
  output logic        [mavg_pkg::WL_W-1:0]      fill_count,
  input  mavg_pkg::mavg_cmd_t                   cmd,
  output mavg_pkg::mavg_status_t                sts
);
  import mavg_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (CNT_W > WL_W) ? CNT_W : WL_W;

  // Ring store of samples; an entry read before it is written is never used.
  logic [SAMPLE_W-1:0] store [MAX_WINDOW];

  logic        [WL_W-1:0]     window_length;
  logic signed [SAMPLE_W-1:0] sample_reg;
  logic signed [SAMPLE_W-1:0] oldest;
  logic        [PTR_W-1:0]    head;
  logic        [CNT_W-1:0]    count;
  logic signed [SUM_W-1:0]    sum;
  logic                       neg;
  logic        [SUM_W-1:0]    dvd;
  logic        [CNT_W-1:0]    rem;

  logic        [CMP_W-1:0]    wl_ext;
  logic        [CMP_W-1:0]    eff_window;
  logic                       drop;
  logic        [CNT_W:0]      slot_raw;
  logic        [PTR_W-1:0]    slot;
  logic        [PTR_W-1:0]    head_inc;
  logic signed [SUM_W:0]      sum_wide;
  logic        [CNT_W:0]      rem_sh;
  logic        [CNT_W:0]      diff;
  logic        [SAMPLE_W-1:0] quo;

  // Window register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_length <= cfg_wr_data;
    end
  end

  // Effective window: zero counts as one, large values clamp to the depth.
  always_comb begin
    wl_ext = CMP_W'(window_length);
    if (wl_ext == '0) begin
      eff_window = CMP_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      eff_window = CMP_W'(MAX_WINDOW);
    end else begin
      eff_window = wl_ext;
    end
  end

  // The oldest sample leaves when the window is already full.
  assign drop = CMP_W'(count) >= eff_window;

  // Write slot is head plus count, modulo the ring depth.
  always_comb begin
    slot_raw = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
    if (slot_raw >= (CNT_W + 1)'(MAX_WINDOW)) begin
      slot = PTR_W'(slot_raw - (CNT_W + 1)'(MAX_WINDOW));
    end else begin
      slot = PTR_W'(slot_raw);
    end
  end

  assign head_inc = (head == PTR_W'(MAX_WINDOW - 1)) ? '0 : head + 1'b1;

  // New sum: add the sample and take out the departing one.
  assign sum_wide = (SUM_W + 1)'(sum) + (SUM_W + 1)'(sample_reg)
                  - (drop ? (SUM_W + 1)'(oldest) : '0);

  // Ring store: read the oldest entry on capture, write the new sample on update.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_reg <= sample;
      oldest     <= store[head];
    end
    if (cmd.update) begin
      store[slot] <= sample_reg;
    end
  end

  // Pointer, count and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.update) begin
      sum <= SUM_W'(sum_wide);
      if (drop) begin
        head <= head_inc;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // Restoring divider step: one quotient bit shifts into the dividend register.
  assign rem_sh = {rem, dvd[SUM_W-1]};
  assign diff   = rem_sh - (CNT_W + 1)'(count);
  assign quo    = dvd[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= sum[SUM_W-1];
      dvd <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem <= '0;
    end else if (cmd.step) begin
      if (!diff[CNT_W]) begin
        rem <= diff[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CNT_W-1:0];
        dvd <= {dvd[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Output register.
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      mean       <= neg ? -quo : quo;
      fill_count <= WL_W'(count);
    end
  end

endmodule

@@ sv/moving_average_window.sv @@
// Channel   Dir  Fields               Handshake
// samples   in   sample[31:0] signed  valid/ready
// results   out  mean[31:0] signed,   valid/ready
//                fill_count[6:0]
// cfg       in   cfg_wr_data[6:0]     cfg_wr_en, no wait
//
// One sample holds the controller through the update, load, divide and deliver states,
// with the restoring divider producing one quotient bit per cycle; the result turns
// valid when the deliver state moves the signed quotient into the output register.
// A sample is taken only while the controller is idle; the next one can be
// accepted while the previous result still sits in the output register.
// A stalled result holds the controller before it delivers the following one.
// Reset is synchronous; it clears the sum, count, pointer and output valid, and
// returns the window register to 50.
module moving_average_window #(
  parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mavg_pkg::WL_W-1:0]     cfg_wr_data,
  mavg_sample_if.sink                   samples,
  mavg_result_if.source                 results
);
  import mavg_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  mavg_cmd_t    cmd;
  mavg_status_t sts;

  // Sequencing of one item.
  mavg_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Ring store, running sum, divider and output register.
  mavg_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SUM_W      (SUM_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (samples.sample),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .mean        (results.mean),
    .fill_count  (results.fill_count),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

@@ sv/mavg_checker.sv @@
module mavg_checker #(
  parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [mavg_pkg::SAMPLE_W-1:0] mean,
  input logic        [mavg_pkg::WL_W-1:0]     fill_count
);
  import mavg_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // Items are worked on one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input ready stayed high after an item was accepted");

  // No result without an item behind it, and at most two items in flight.
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd3) && (!out_valid || (pending != 2'd0)))
    else $error("result count does not match accepted items");

  // The fill count shown is at least one and within the ring depth.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count != '0) && (int'(fill_count) <= MAX_WINDOW))
    else $error("fill count out of range");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean) && $stable(fill_count))
    else $error("stalled result changed");

endmodule

bind moving_average_window mavg_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_mavg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .mean       (results.mean),
  .fill_count (results.fill_count)
);
